### hw/rtl/vcb_pkg.sv
// shared types and constants of the vertex cache triangle batcher
`default_nettype none

package vcb_pkg;

	localparam int CACHE_SLOTS = 32;
	localparam int SLOT_W      = $clog2(CACHE_SLOTS);
	localparam int USED_W      = $clog2(CACHE_SLOTS + 1);
	localparam int IDX_W       = 16;
	localparam int POS_W       = 24;
	localparam int CAP_W       = 6;
	localparam int CAP_MIN     = 3;
	localparam int CORNERS     = 3;
	localparam int CORNER_W    = 2;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 64;

	typedef enum logic [1:0] {
		KIND_BATCH = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_TRI   = 2'd2
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic                load_item;
		logic                clear_mesh;
		logic                look_en;
		logic [CORNER_W-1:0] look_idx;
		logic                reset_batch;
		logic                load_en;
		logic [CORNER_W-1:0] load_idx;
		logic                emit;
		kind_t               kind;
	} vcb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic               out_free;
		logic               overflow;
		logic [CORNERS-1:0] hit;
	} vcb_sts_t;

endpackage

`default_nettype wire

### hw/rtl/vertex_cache_triangle_batcher_unit.sv
// top level of the vertex cache triangle batcher
//
// channel  dir  handshake          contents
// s_*      in   s_tvalid/s_tready  one triangle: tdata corners a,b,c; tuser start_mesh
// m_*      out  m_tvalid/m_tready  one result beat: tdata payload, tuser kind, tlast
// cfg_*    in   cfg_we             batch_capacity, no read-back
//
// steps: accept, a new-batch beat when start_mesh is set, three lookups
//   through the shared compare bank, overflow check, three corner steps,
//   triangle beat; every emitted beat waits for the output register
// reset: arst_n clears the controller, slot count, position count and the
//   output valid; capacity comes up as 32, slot tags are not cleared
// stalls: m_tready low holds the sequencer only at a beat it wants to emit;
//   the next triangle is taken while the final beat still waits
`default_nettype none

module vertex_cache_triangle_batcher_unit
	import vcb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CAP_W-1:0]      cfg_wdata,   // batch_capacity
	// triangle input
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,     // vertex_a, vertex_b, vertex_c
	input  wire logic [0:0]            s_tuser,     // start_mesh
	// result output
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,     // source_vertex, load_slot,
	                                                // out_position, slot_first,
	                                                // slot_second, slot_third, pad
	output logic [1:0]                 m_tuser,     // kind
	output logic                       m_tlast      // last
);

	vcb_cmd_t cmd;
	vcb_sts_t sts;

	// sequencer
	vcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_start (s_tuser[0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tags, counters and output register
	vcb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

`ifndef SYNTHESIS
	// nothing is emitted in the cycle a triangle is taken
	a_no_emit_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !cmd.emit)
		else $error("beat emitted while accepting a triangle");

	// a beat is only loaded when the output register can take it
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("output register overwritten");

	// the block is busy right after taking a triangle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready right after accept");

	// after the triangle beat the block is ready again
	a_ready_after_tri: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.kind == KIND_TRI) |=> s_tready)
		else $error("not ready after triangle beat");
`endif

endmodule

`default_nettype wire

### hw/rtl/vcb_ctrl.sv
// sequencer of the batcher: lookup, overflow check, loads, triangle beat
`default_nettype none

module vcb_ctrl
	import vcb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_start,
	output logic          in_ready,
	input  wire vcb_sts_t sts,
	output vcb_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_LOAD  = 3'd4;
	localparam logic [2:0] S_TRI   = 3'd5;

	localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(CORNERS - 1);

	logic [2:0]          state_q, state_d;
	logic [CORNER_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = KIND_BATCH;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = in_start ? S_START : S_LOOK;
				end
			end
			S_START: begin
				if (sts.out_free) begin
					cmd.emit       = 1'b1;
					cmd.kind       = KIND_BATCH;
					cmd.clear_mesh = 1'b1;
					state_d        = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look_en  = 1'b1;
				cmd.look_idx = cnt_q;
				if (cnt_q == LAST_CORNER) begin
					cnt_d   = '0;
					state_d = S_CHECK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_CHECK: begin
				if (!sts.overflow) begin
					state_d = S_LOAD;
				end else if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.kind        = KIND_BATCH;
					cmd.reset_batch = 1'b1;
					state_d         = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_idx = cnt_q;
				if (sts.hit[cnt_q] || sts.out_free) begin
					if (!sts.hit[cnt_q]) begin
						cmd.emit    = 1'b1;
						cmd.kind    = KIND_LOAD;
						cmd.load_en = 1'b1;
					end
					if (cnt_q == LAST_CORNER) begin
						cnt_d   = '0;
						state_d = S_TRI;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			S_TRI: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_TRI;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/vcb_dp.sv
// datapath: slot tags, shared lookup unit, counters and output register
`default_nettype none

module vcb_dp
	import vcb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire vcb_cmd_t              cmd,
	output vcb_sts_t                   sts,
	input  wire logic [IN_DATA_W-1:0]  in_data,
	input  wire logic                  cfg_we,
	input  wire logic [CAP_W-1:0]      cfg_wdata,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_DATA_W-1:0]      out_data,
	output logic [1:0]                 out_kind,
	output logic                       out_last
);

	logic [IDX_W-1:0]  tags_q [CACHE_SLOTS];
	logic [IDX_W-1:0]  vtx_q  [CORNERS];
	logic [SLOT_W-1:0] slot_q [CORNERS];
	logic [CORNERS-1:0] hit_q;
	logic [USED_W-1:0] used_q;
	logic [POS_W-1:0]  emitted_q;
	logic [CAP_W-1:0]  cap_q;
	logic              out_valid_q;

	logic [IDX_W-1:0]  out_src_q;
	logic [SLOT_W-1:0] out_lslot_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [SLOT_W-1:0] out_s0_q, out_s1_q, out_s2_q;
	kind_t             out_kind_q;
	logic              out_last_q;

	// lookup of one corner against the slots in use, lowest slot wins
	logic [IDX_W-1:0]  look_v;
	logic              look_hit;
	logic [SLOT_W-1:0] look_slot;

	always_comb begin
		look_v    = vtx_q[cmd.look_idx];
		look_hit  = 1'b0;
		look_slot = '0;
		for (int j = CACHE_SLOTS - 1; j >= 0; j--) begin
			if ((USED_W'(j) < used_q) && (tags_q[j] == look_v)) begin
				look_hit  = 1'b1;
				look_slot = SLOT_W'(j);
			end
		end
	end

	// capacity clamped into the usable range
	logic [CAP_W-1:0] cap_eff;
	always_comb begin
		priority if (cap_q < CAP_W'(CAP_MIN))
			cap_eff = CAP_W'(CAP_MIN);
		else if (cap_q > CAP_W'(CACHE_SLOTS))
			cap_eff = CAP_W'(CACHE_SLOTS);
		else
			cap_eff = cap_q;
	end

	logic [1:0]        misses;
	logic [USED_W:0]   need;
	assign misses = 2'(!hit_q[0]) + 2'(!hit_q[1]) + 2'(!hit_q[2]);
	assign need   = {1'b0, used_q} + (USED_W + 1)'(misses);

	// insert slot, capped at the last slot
	logic [SLOT_W-1:0] ins_slot;
	assign ins_slot = (used_q >= USED_W'(CACHE_SLOTS)) ? SLOT_W'(CACHE_SLOTS - 1)
		: used_q[SLOT_W-1:0];

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	assign sts.out_free = out_free;
	assign sts.overflow = need > (USED_W + 1)'(cap_eff);
	assign sts.hit      = hit_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			emitted_q   <= '0;
			cap_q       <= CAP_W'(CACHE_SLOTS);
			hit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (cmd.clear_mesh) begin
				used_q    <= '0;
				emitted_q <= '0;
			end
			if (cmd.look_en)
				hit_q[cmd.look_idx] <= look_hit;
			if (cmd.reset_batch) begin
				used_q <= '0;
				hit_q  <= '0;
			end
			if (cmd.load_en) begin
				used_q    <= USED_W'(ins_slot) + 1'b1;
				emitted_q <= emitted_q + 1'b1;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			vtx_q[0] <= in_data[IDX_W-1:0];
			vtx_q[1] <= in_data[2*IDX_W-1:IDX_W];
			vtx_q[2] <= in_data[3*IDX_W-1:2*IDX_W];
		end
		if (cmd.look_en)
			slot_q[cmd.look_idx] <= look_slot;
		if (cmd.load_en) begin
			tags_q[ins_slot]     <= vtx_q[cmd.load_idx];
			slot_q[cmd.load_idx] <= ins_slot;
		end
		if (cmd.emit) begin
			out_kind_q  <= cmd.kind;
			out_src_q   <= '0;
			out_lslot_q <= '0;
			out_pos_q   <= '0;
			out_s0_q    <= '0;
			out_s1_q    <= '0;
			out_s2_q    <= '0;
			out_last_q  <= 1'b0;
			unique case (cmd.kind)
				KIND_BATCH: begin
					out_pos_q <= cmd.clear_mesh ? '0 : emitted_q;
				end
				KIND_LOAD: begin
					out_src_q   <= vtx_q[cmd.load_idx];
					out_lslot_q <= ins_slot;
					out_pos_q   <= emitted_q;
				end
				KIND_TRI: begin
					out_s0_q   <= slot_q[0];
					out_s1_q   <= slot_q[1];
					out_s2_q   <= slot_q[2];
					out_last_q <= 1'b1;
				end
				default: begin
					out_last_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;
	assign out_data  = {4'b0, out_s2_q, out_s1_q, out_s0_q, out_pos_q, out_lslot_q, out_src_q};

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench for the vertex cache triangle batcher top level
`timescale 1ns / 1ps

module tb_top;
	import vcb_pkg::*;

	// one expected or observed result beat, fields as the block defines them
	typedef struct {
		kind_t               kind;
		logic [IDX_W-1:0]    source;
		logic [SLOT_W-1:0]   load_slot;
		logic [POS_W-1:0]    position;
		logic [SLOT_W-1:0]   corner0;
		logic [SLOT_W-1:0]   corner1;
		logic [SLOT_W-1:0]   corner2;
		logic                final_beat;
	} batch_beat_t;

	// one directed triangle; typed rows carry the corner slots read straight off the spec
	typedef struct {
		bit                  start;
		logic [IDX_W-1:0]    a;
		logic [IDX_W-1:0]    b;
		logic [IDX_W-1:0]    c;
		bit                  typed;
		logic [SLOT_W-1:0]   t0;
		logic [SLOT_W-1:0]   t1;
		logic [SLOT_W-1:0]   t2;
	} tri_row_t;

	localparam int DIRECTED_ROWS = 19;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 21;
	localparam int SETTLE_CYCLES = 20;   // about two items with a start

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CAP_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	// predictor state: slot contents, fill level, load counter, capacity register
	logic [IDX_W-1:0]      slot_ids [CACHE_SLOTS];
	int unsigned           slots_in_use = 0;
	logic [POS_W-1:0]      loads_issued = '0;
	logic [CAP_W-1:0]      capacity = 6'd32;

	batch_beat_t           pending_beats [$];
	logic [IDX_W-1:0]      recent_ids [$];
	tri_row_t              directed_rows [DIRECTED_ROWS];

	bit                    steady_flow = 1'b0;   // no gaps and no stalls on either side
	int                    mismatches = 0;
	int                    beats_checked = 0;
	int                    batch_beats = 0;
	int                    triangles_sent = 0;
	int                    settings_used = 0;

	vertex_cache_triangle_batcher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // vertex_a, vertex_b, vertex_c
		.s_tuser  (s_tuser),    // start_mesh
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // source_vertex, load_slot, out_position, slot_first,
		                        // slot_second, slot_third, pad
		.m_tuser  (m_tuser),    // kind
		.m_tlast  (m_tlast)     // last
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic batch_beat_t make_beat(kind_t k, logic [IDX_W-1:0] src,
			logic [SLOT_W-1:0] ls, logic [POS_W-1:0] pos, logic [SLOT_W-1:0] c0,
			logic [SLOT_W-1:0] c1, logic [SLOT_W-1:0] c2, logic fin);
		batch_beat_t r;
		r.kind       = k;
		r.source     = src;
		r.load_slot  = ls;
		r.position   = pos;
		r.corner0    = c0;
		r.corner1    = c1;
		r.corner2    = c2;
		r.final_beat = fin;
		return r;
	endfunction

	// batch one triangle and queue the beats it should produce
	function automatic void batch_triangle(bit start, logic [IDX_W-1:0] a,
			logic [IDX_W-1:0] b, logic [IDX_W-1:0] c);
		logic [IDX_W-1:0]  ids [3];
		bit                found [3];
		logic [SLOT_W-1:0] slot [3];
		int unsigned       misses;
		int unsigned       cap;
		int unsigned       s;
		ids    = '{a, b, c};
		misses = 0;
		// out-of-range capacity clamps into 3..CACHE_SLOTS
		cap = capacity;
		if (cap < CAP_MIN)
			cap = CAP_MIN;
		if (cap > CACHE_SLOTS)
			cap = CACHE_SLOTS;
		if (start) begin
			slots_in_use = 0;
			loads_issued = '0;
			pending_beats.push_back(make_beat(KIND_BATCH, '0, '0, '0, '0, '0, '0, 1'b0));
		end
		// every lookup sees the buffer as it was before this triangle, lowest slot wins
		for (int i = 0; i < 3; i++) begin
			found[i] = 1'b0;
			slot[i]  = '0;
			for (int j = 0; j < int'(slots_in_use); j++) begin
				if (!found[i] && slot_ids[j] == ids[i]) begin
					found[i] = 1'b1;
					slot[i]  = SLOT_W'(j);
				end
			end
			if (!found[i])
				misses++;
		end
		// overflow: start a fresh batch and drop all hits
		if (slots_in_use + misses > cap) begin
			pending_beats.push_back(make_beat(KIND_BATCH, '0, '0, loads_issued, '0, '0, '0,
				1'b0));
			slots_in_use = 0;
			found = '{1'b0, 1'b0, 1'b0};
		end
		for (int i = 0; i < 3; i++) begin
			if (!found[i]) begin
				s = slots_in_use;
				if (s >= CACHE_SLOTS)
					s = CACHE_SLOTS - 1;
				slot_ids[s]  = ids[i];
				slot[i]      = SLOT_W'(s);
				slots_in_use = s + 1;
				pending_beats.push_back(make_beat(KIND_LOAD, ids[i], SLOT_W'(s), loads_issued,
					'0, '0, '0, 1'b0));
				loads_issued = loads_issued + 1'b1;
			end
		end
		pending_beats.push_back(make_beat(KIND_TRI, '0, '0, '0, slot[0], slot[1], slot[2],
			1'b1));
	endfunction

	function automatic void compare_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// mesh-like corner: mostly a recently used vertex, else a fresh one
	function automatic logic [IDX_W-1:0] pick_corner();
		if (recent_ids.size() != 0 && $urandom_range(0, 9) < 6)
			return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
		if ($urandom_range(0, 3) == 0)
			return IDX_W'($urandom_range(0, 31));
		return IDX_W'($urandom_range(0, 65535));
	endfunction

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		capacity  = value;
		settings_used++;
	endtask

	// offer one triangle, after a random gap unless steady, and predict it at the accepting edge
	task automatic send_triangle(input tri_row_t row);
		int          gap;
		batch_beat_t tail;
		gap = steady_flow ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.c, row.b, row.a};
		s_tuser  <= row.start;
		do
			@(posedge clk);
		while (!s_tready);
		batch_triangle(row.start, row.a, row.b, row.c);
		// typed rows pin the triangle beat to the slots written in the table
		if (row.typed) begin
			tail = pending_beats.pop_back();
			tail.corner0 = row.t0;
			tail.corner1 = row.t1;
			tail.corner2 = row.t2;
			pending_beats.push_back(tail);
		end
		triangles_sent++;
	endtask

	// drop valid, drain every expected beat, then give the sequencer time to settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls per beat unless steady, each accepted beat checked against the oldest
	initial begin
		int          stall;
		batch_beat_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			beats_checked++;
			if (pending_beats.size() == 0) begin
				$error("result beat with nothing expected: kind %0d tdata %h", m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				if (want.kind == KIND_BATCH)
					batch_beats++;
				compare_field("kind", want.kind, m_tuser);
				compare_field("source_vertex", want.source, m_tdata[15:0]);
				compare_field("load_slot", want.load_slot, m_tdata[20:16]);
				compare_field("out_position", want.position, m_tdata[44:21]);
				compare_field("slot_first", want.corner0, m_tdata[49:45]);
				compare_field("slot_second", want.corner1, m_tdata[54:50]);
				compare_field("slot_third", want.corner2, m_tdata[59:55]);
				compare_field("last", want.final_beat, m_tlast);
			end
		end
	end

	// stimulus: reset, directed table at reset capacity, then random phases per setting
	initial begin
		logic [CAP_W-1:0] phase_caps [PHASES];
		tri_row_t         row;
		foreach (slot_ids[i])
			slot_ids[i] = '0;
		// extremes of the register, in and out of range, plus one random pick at the end
		phase_caps = '{6'd3, 6'd0, 6'd1, 6'd2, 6'd63, 6'd32, 6'd33, 6'd4, 6'd17, 6'd9};
		phase_caps[PHASES-1] = CAP_W'($urandom_range(0, 63));

		directed_rows = '{
			// start on a fresh mesh, then the same triangle as all hits
			'{1'b1, 16'h0000, 16'h0001, 16'h0002, 1'b1, 5'd0, 5'd1, 5'd2},
			'{1'b0, 16'h0000, 16'h0001, 16'h0002, 1'b1, 5'd0, 5'd1, 5'd2},
			// a vertex repeated in a missing triangle is loaded once per corner
			'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd3, 5'd4, 5'd5},
			// hits take the lowest matching slot
			'{1'b0, 16'hFFFF, 16'h0002, 16'h0000, 1'b1, 5'd3, 5'd2, 5'd0},
			// start mid-batch clears everything
			'{1'b1, 16'hFFFF, 16'h0000, 16'h8000, 1'b1, 5'd0, 5'd1, 5'd2},
			// fill up to 30 slots
			'{1'b0, 16'h0100, 16'h0101, 16'h0102, 1'b0, 5'd0, 5'd0, 5'd0},
			'{1'b0, 16'h0103, 16'h0104, 16'h0105, 1'b0, 5'd0, 5'd0, 5'd0},
			'{1'b0, 16'h0106, 16'h0107, 16'h0108, 1'b0, 5'd0, 5'd0, 5'd0},
			'{1'b0, 16'h0109, 16'h010A, 16'h010B, 1'b0, 5'd0, 5'd0, 5'd0},
			'{1'b0, 16'h010C, 16'h010D, 16'h010E, 1'b0, 5'd0, 5'd0, 5'd0},
			'{1'b0, 16'h010F, 16'h0110, 16'h0111, 1'b0, 5'd0, 5'd0, 5'd0},
			'{1'b0, 16'h0112, 16'h0113, 16'h0114, 1'b0, 5'd0, 5'd0, 5'd0},
			'{1'b0, 16'h0115, 16'h0116, 16'h0117, 1'b0, 5'd0, 5'd0, 5'd0},
			'{1'b0, 16'h0118, 16'h0119, 16'h011A, 1'b0, 5'd0, 5'd0, 5'd0},
			// three more misses overflow 32 slots, new batch starts at slot 0
			'{1'b0, 16'h7000, 16'h7001, 16'h7002, 1'b1, 5'd0, 5'd1, 5'd2},
			// mixed hit, miss, hit
			'{1'b0, 16'h7001, 16'h1234, 16'h7000, 1'b1, 5'd1, 5'd3, 5'd0},
			// start with extremes of the index field
			'{1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 5'd0, 5'd1, 5'd2},
			'{1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 5'd3, 5'd4, 5'd5},
			'{1'b0, 16'h5555, 16'hFFFF, 16'h0000, 1'b1, 5'd4, 5'd0, 5'd1}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_triangle(directed_rows[r]);
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_caps[p]);
			steady_flow = (p % 3 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				row.typed = 1'b0;
				row.t0    = '0;
				row.t1    = '0;
				row.t2    = '0;
				if ($urandom_range(0, 9) == 0) begin
					// noise: fully random fields
					row.start = ($urandom_range(0, 3) == 0);
					row.a     = IDX_W'($urandom_range(0, 65535));
					row.b     = IDX_W'($urandom_range(0, 65535));
					row.c     = IDX_W'($urandom_range(0, 65535));
				end else begin
					row.start = ($urandom_range(0, 24) == 0);
					row.a     = pick_corner();
					row.b     = pick_corner();
					row.c     = pick_corner();
				end
				recent_ids.push_back(row.a);
				recent_ids.push_back(row.b);
				recent_ids.push_back(row.c);
				while (recent_ids.size() > 12)
					void'(recent_ids.pop_front());
				send_triangle(row);
			end
			drain_results();
		end
		steady_flow = 1'b0;

		$display("sent %0d triangles under %0d capacity settings plus the reset value",
			triangles_sent, settings_used);
		$display("checked %0d result beats, %0d of them new-batch beats",
			beats_checked, batch_beats);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("vertex_cache_triangle_batcher_unit test passed");
		else
			$display("vertex_cache_triangle_batcher_unit test failed");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#400000;
		$display("vertex_cache_triangle_batcher_unit test failed");
		$finish;
	end

endmodule
